// File: hw/rtl/mhbe_pkg.sv
package mhbe_pkg;

    localparam int KEY_W        = 32;
    localparam int PAY_W        = 32;
    localparam int LEFT_W       = 5;
    localparam int OP_W         = 2;
    localparam int ST_W         = 2;
    localparam int CAPACITY_DEF = 16;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD   = 2'd1;
    localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // One heap entry as held in the store
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [PAY_W-1:0] payload;
    } t_entry;

    // One result item
    typedef struct packed {
        logic        [ST_W-1:0]   status;
        logic signed [KEY_W-1:0]  out_key;
        logic        [PAY_W-1:0]  out_payload;
        logic        [LEFT_W-1:0] entries_left;
    } t_result;

endpackage

// File: hw/rtl/max_heap_build_extract_top.sv
// Load writes the item unless the heap is full; load and op 3 go straight to their result.
// Extract on an ordered heap reads the root and the last entry and sifts that entry down, each
// level through S_SIFT, S_LEFT, S_RIGHT (if a right child exists), S_DEC. Build sifts down each
// parent from the last to the root; extract on an unbuilt heap runs a build first.
// One item at a time; the output register lets the next item start while a result waits.
// Synchronous active-low reset empties the heap and marks it ordered; store contents are kept.
module max_heap_build_extract_top
    import mhbe_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [OP_W-1:0]          i_op,
    input  logic signed [KEY_W-1:0]  i_item_key,
    input  logic [PAY_W-1:0]         i_item_payload,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [ST_W-1:0]          o_status,
    output logic signed [KEY_W-1:0]  o_out_key,
    output logic [PAY_W-1:0]         o_out_payload,
    output logic [LEFT_W-1:0]        o_entries_left
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // store port between sequencer and memory
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    t_entry        w_rdata;

    // finished result from the sequencer
    logic    w_res_valid;
    t_result w_res;
    logic    w_res_take;

    // output register
    logic    r_out_valid;
    t_result r_out;

    // Take a finished result whenever the output register is empty or being drained.
    assign w_res_take = w_res_valid && (!r_out_valid || i_ready);

    // Sequencer: decodes each item, runs build and extract sift-downs over the store,
    // and holds the result until the output register has room.
    mhbe_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_valid),
        .o_cmd_ready (o_ready),
        .i_op        (i_op),
        .i_key       (i_item_key),
        .i_payload   (i_item_payload),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take),
        .o_mem_we    (w_we),
        .o_mem_waddr (w_waddr),
        .o_mem_wdata (w_wdata),
        .o_mem_re    (w_re),
        .o_mem_raddr (w_raddr),
        .i_mem_rdata (w_rdata)
    );

    // Entry store: key and payload side by side, one write and one read port,
    // read data registered.
    mhbe_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Hold the result item until taken; refill in the same cycle it drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_out_key      = r_out.out_key;
    assign o_out_payload  = r_out.out_payload;
    assign o_entries_left = r_out.entries_left;

endmodule

// File: hw/rtl/mhbe_store.sv
module mhbe_store
    import mhbe_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/mhbe_ctrl.sv
module mhbe_ctrl
    import mhbe_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int IW = AW + 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    output logic                    o_cmd_ready,
    input  logic [OP_W-1:0]         i_op,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [PAY_W-1:0]        i_payload,
    output logic                    o_res_valid,
    output t_result                 o_res,
    input  logic                    i_res_take,
    output logic                    o_mem_we,
    output logic [AW-1:0]           o_mem_waddr,
    output t_entry                  o_mem_wdata,
    output logic                    o_mem_re,
    output logic [AW-1:0]           o_mem_raddr,
    input  t_entry                  i_mem_rdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_BNEXT, S_BCUR, S_SIFT, S_LEFT, S_RIGHT, S_DEC,
        S_XROOT, S_XHEAD, S_XLAST, S_FIN
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ordered, n_ordered;
    logic            r_then_ext, n_then_ext;
    logic            r_in_build, n_in_build;
    logic [CW-1:0]   r_bi, n_bi;
    logic [AW-1:0]   r_node, n_node;
    t_entry          r_cur, n_cur;
    t_entry          r_best, n_best;
    logic [AW-1:0]   r_best_idx, n_best_idx;
    logic            r_best_child, n_best_child;
    t_result         r_res, n_res;

    logic [IW-1:0]      w_left;
    logic [IW-1:0]      w_right;
    logic [IW-1:0]      w_count_ext;
    logic [CW+LEFT_W-1:0] w_count_wide;
    t_state             w_after;

    assign w_left       = IW'({r_node, 1'b1});
    assign w_right      = IW'({r_node, 1'b0}) + IW'(2);
    assign w_count_ext  = IW'(r_count);
    assign w_count_wide = {{LEFT_W{1'b0}}, r_count};
    assign w_after      = r_in_build ? S_BNEXT : S_FIN;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);

    always_comb begin
        o_res              = r_res;
        o_res.entries_left = w_count_wide[LEFT_W-1:0];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ordered    = r_ordered;
        n_then_ext   = r_then_ext;
        n_in_build   = r_in_build;
        n_bi         = r_bi;
        n_node       = r_node;
        n_cur        = r_cur;
        n_best       = r_best;
        n_best_idx   = r_best_idx;
        n_best_child = r_best_child;
        n_res        = r_res;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_node;
        o_mem_wdata  = r_cur;
        o_mem_re     = 1'b0;
        o_mem_raddr  = r_node;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_res        = '0;
                    n_res.status = ST_OK;
                    n_state      = S_FIN;
                    case (i_op)
                        OP_LOAD: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                o_mem_we            = 1'b1;
                                o_mem_waddr         = AW'(r_count);
                                o_mem_wdata.key     = i_key;
                                o_mem_wdata.payload = i_payload;
                                n_count             = r_count + CW'(1);
                                n_ordered           = 1'b0;
                            end
                        end
                        OP_BUILD: begin
                            n_bi       = r_count >> 1;
                            n_then_ext = 1'b0;
                            n_state    = S_BNEXT;
                        end
                        OP_EXTRACT: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else if (!r_ordered) begin
                                n_bi       = r_count >> 1;
                                n_then_ext = 1'b1;
                                n_state    = S_BNEXT;
                            end else begin
                                n_state = S_XROOT;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_BNEXT: begin
                if (r_bi == '0) begin
                    n_ordered  = 1'b1;
                    n_then_ext = 1'b0;
                    n_state    = r_then_ext ? S_XROOT : S_FIN;
                end else begin
                    n_bi        = r_bi - CW'(1);
                    n_node      = AW'(r_bi - CW'(1));
                    n_in_build  = 1'b1;
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(r_bi - CW'(1));
                    n_state     = S_BCUR;
                end
            end
            S_BCUR: begin
                n_cur   = i_mem_rdata;
                n_state = S_SIFT;
            end
            S_SIFT: begin
                if (w_left >= w_count_ext) begin
                    // leaf reached: settle the held entry here
                    o_mem_we = 1'b1;
                    n_state  = w_after;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(w_left);
                    n_state     = S_LEFT;
                end
            end
            S_LEFT: begin
                if (r_cur.key < i_mem_rdata.key) begin
                    n_best       = i_mem_rdata;
                    n_best_idx   = AW'(w_left);
                    n_best_child = 1'b1;
                end else begin
                    n_best       = r_cur;
                    n_best_child = 1'b0;
                end
                if (w_right < w_count_ext) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(w_right);
                    n_state     = S_RIGHT;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_RIGHT: begin
                if (r_best.key < i_mem_rdata.key) begin
                    n_best       = i_mem_rdata;
                    n_best_idx   = AW'(w_right);
                    n_best_child = 1'b1;
                end
                n_state = S_DEC;
            end
            S_DEC: begin
                o_mem_we = 1'b1;
                if (r_best_child) begin
                    o_mem_wdata = r_best;
                    n_node      = r_best_idx;
                    n_state     = S_SIFT;
                end else begin
                    n_state = w_after;
                end
            end
            S_XROOT: begin
                n_in_build  = 1'b0;
                o_mem_re    = 1'b1;
                o_mem_raddr = '0;
                n_state     = S_XHEAD;
            end
            S_XHEAD: begin
                n_res.out_key     = i_mem_rdata.key;
                n_res.out_payload = i_mem_rdata.payload;
                n_count           = r_count - CW'(1);
                o_mem_re          = 1'b1;
                o_mem_raddr       = AW'(r_count - CW'(1));
                n_state           = S_XLAST;
            end
            S_XLAST: begin
                n_cur   = i_mem_rdata;
                n_node  = '0;
                n_state = S_SIFT;
            end
            S_FIN: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ordered  <= 1'b1;
            r_then_ext <= 1'b0;
            r_in_build <= 1'b0;
            r_bi       <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ordered  <= n_ordered;
            r_then_ext <= n_then_ext;
            r_in_build <= n_in_build;
            r_bi       <= n_bi;
        end
        r_node       <= n_node;
        r_cur        <= n_cur;
        r_best       <= n_best;
        r_best_idx   <= n_best_idx;
        r_best_child <= n_best_child;
        r_res        <= n_res;
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_read_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_re |-> (IW'(o_mem_raddr) < w_count_ext))
        else $error("read of an entry past the visible count");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_ready && i_cmd_valid && i_op == OP_LOAD && r_count == CW'(CAPACITY))
        |=> (r_count == $past(r_count) && o_res.status == ST_FULL))
        else $error("load on a full heap changed the count");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && r_state == S_IDLE) |-> (i_cmd_valid && i_op == OP_LOAD))
        else $error("store written while idle");

endmodule
